[design/mbps_pkg.sv]
// ---------------------------------------------------------------------------
// mbps_pkg: shared types and constants of the masked byte pattern scanner
// Register codes, compare bundle for the cell row and the result beat type.
// ---------------------------------------------------------------------------
package mbps_pkg;

  // fixed field widths
  localparam int unsigned PAT_BYTES = 32;  // configurable pattern bytes
  localparam int unsigned LEN_W     = 6;   // pattern_length register
  localparam int unsigned ADDR_W    = 48;  // region_base / match_address
  localparam int unsigned SEEN_W    = 32;  // byte counter
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 64;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LOW    = 3'd0,
    REG_PAT_SECOND = 3'd1,
    REG_PAT_THIRD  = 3'd2,
    REG_PAT_HIGH   = 3'd3,
    REG_CARE       = 3'd4,
    REG_LEN        = 3'd5,
    REG_BASE       = 3'd6
  } cfg_reg_e;

  // pattern view shared by every cell of the row
  typedef struct packed {
    logic [PAT_BYTES-1:0][7:0] pat;
    logic [PAT_BYTES-1:0]      care;
    logic [LEN_W-1:0]          len;   // already clamped to 1..cap
  } cmp_cfg_t;

  // one result beat
  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] addr;
  } res_t;

  // output buffer occupancy
  typedef struct packed {
    logic head_vld;
    logic skid_vld;
  } buf_status_t;

endpackage

[design/mbps_cell.sv]
// ---------------------------------------------------------------------------
// mbps_cell: one window byte of the scanner
// Holds one byte of the sliding window, passes it on to the next cell on
// every shift and checks the incoming byte against its pattern position.
// ---------------------------------------------------------------------------
module mbps_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic               clk_i,
  input  logic               shift_en_i,
  input  logic [7:0]         byte_i,    // byte this cell takes on the shift
  input  mbps_pkg::cmp_cfg_t cmp_i,
  output logic [7:0]         byte_o,    // held byte, feeds the next cell
  output logic               hit_o      // incoming byte agrees or is don't-care
);
  import mbps_pkg::*;

  logic [7:0] byte_q;

  // window byte, no reset needed: the byte count guards stale contents
  always_ff @(posedge clk_i) begin
    if (shift_en_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;

  // compare against pattern byte len-1-IDX (window is newest first)
  generate
    if (IDX < PAT_BYTES) begin : g_cmp
      logic                         active;
      logic [LEN_W-1:0]             sel;
      logic [$clog2(PAT_BYTES)-1:0] pos;

      assign active = (LEN_W'(IDX) < cmp_i.len);
      assign sel    = cmp_i.len - LEN_W'(IDX + 1);
      assign pos    = sel[$clog2(PAT_BYTES)-1:0];
      assign hit_o  = !active || !cmp_i.care[pos] || (cmp_i.pat[pos] == byte_i);
    end else begin : g_idle
      // beyond the longest pattern: never part of a compare
      assign hit_o = 1'b1;
    end
  endgenerate

endmodule

[design/mbps_obuf.sv]
// ---------------------------------------------------------------------------
// mbps_obuf: two-entry result buffer
// Output register plus skid entry so the scan side keeps taking bytes while
// a result beat waits on the master side.
// ---------------------------------------------------------------------------
module mbps_obuf (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  mbps_pkg::res_t        res_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output mbps_pkg::res_t        res_o,
  output mbps_pkg::buf_status_t status_o
);
  import mbps_pkg::*;

  logic head_vld_q, head_vld_d;
  logic skid_vld_q, skid_vld_d;
  res_t head_q, head_d;
  res_t skid_q, skid_d;
  logic pop;

  assign pop = head_vld_q && ready_i;

  // occupancy and data movement
  always_comb begin
    head_vld_d = head_vld_q;
    skid_vld_d = skid_vld_q;
    head_d     = head_q;
    skid_d     = skid_q;
    if (pop) begin
      if (skid_vld_q) begin
        head_d     = skid_q;
        skid_d     = res_i;
        skid_vld_d = push_i;
      end else begin
        head_d     = res_i;
        head_vld_d = push_i;
      end
    end else if (push_i) begin
      if (!head_vld_q) begin
        head_d     = res_i;
        head_vld_d = 1'b1;
      end else begin
        skid_d     = res_i;
        skid_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      head_vld_q <= head_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  assign valid_o           = head_vld_q;
  assign res_o             = head_q;
  assign status_o.head_vld = head_vld_q;
  assign status_o.skid_vld = skid_vld_q;

endmodule

[design/masked_byte_pattern_scanner.sv]
// ---------------------------------------------------------------------------
// masked_byte_pattern_scanner: wildcard byte pattern search
// Streams a region one byte per beat through a row of window cells and
// reports the address of the first masked match, or not-found at the end.
// ---------------------------------------------------------------------------
//
//  channel   dir  payload                          accepted when
//  s_axis    in   tdata: data_byte, tlast: last    s_axis_tvalid & s_axis_tready
//  m_axis    out  tdata: match_address, tuser: found  m_axis_tvalid & m_axis_tready
//  cfg       in   cfg_index_i, cfg_data_i          cfg_valid_i & cfg_ready_o
//
//  One byte per cycle while s_axis_tready is high; each beat is compared in the
//  cycle it is taken by the cell row; its result beat is registered in the buffer.
//  Reset clears the byte count, the match flag and the result buffer; the
//  configuration comes up as pattern zero, all care bits set, length one.
//  s_axis_tready drops only while both result buffer entries are full.
//  Configuration writes are always taken.
// ---------------------------------------------------------------------------
module masked_byte_pattern_scanner #(
  parameter int unsigned PATTERN_MAX  = 32,
  parameter int unsigned OFFSET_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // byte stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [7:0] data_byte
  input  logic                           s_axis_tlast,
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [mbps_pkg::ADDR_W-1:0]    m_axis_tdata,  // [47:0] match_address
  output logic                           m_axis_tuser,  // [0] found
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mbps_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mbps_pkg::CFG_DAT_W-1:0] cfg_data_i
);
  import mbps_pkg::*;

  localparam int unsigned LenCap = (PATTERN_MAX < PAT_BYTES) ? PATTERN_MAX : PAT_BYTES;
  localparam logic [ADDR_W-1:0] OffMask =
    ADDR_W'((64'(1) << OFFSET_WIDTH) - 64'(1));

  // configuration registers
  logic [PAT_BYTES-1:0][7:0] pat_q;
  logic [PAT_BYTES-1:0]      care_q;
  logic [LEN_W-1:0]          len_q;
  logic [ADDR_W-1:0]         base_q;

  // scan state
  logic [SEEN_W-1:0] seen_q, seen_d;
  logic              matched_q, matched_d;

  logic              accept;
  logic              shift;
  logic [LEN_W-1:0]  eff_len;
  cmp_cfg_t          cmp;
  logic [7:0]        win_in  [PATTERN_MAX];
  logic [7:0]        win_out [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] hits;
  logic [SEEN_W-1:0] seen_new;
  logic [SEEN_W-1:0] diff;
  logic [ADDR_W-1:0] addr;
  logic              match;
  logic              res_push;
  res_t              res_new;
  res_t              res_out;
  buf_status_t       buf_st;

  assign cfg_ready_o = 1'b1;

  // register writes; indexes off the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q  <= '0;
      care_q <= '1;
      len_q  <= LEN_W'(1);
      base_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_PAT_LOW:    pat_q[7:0]   <= cfg_data_i;
        REG_PAT_SECOND: pat_q[15:8]  <= cfg_data_i;
        REG_PAT_THIRD:  pat_q[23:16] <= cfg_data_i;
        REG_PAT_HIGH:   pat_q[31:24] <= cfg_data_i;
        REG_CARE:       care_q       <= cfg_data_i[PAT_BYTES-1:0];
        REG_LEN:        len_q        <= cfg_data_i[LEN_W-1:0];
        REG_BASE:       base_q       <= cfg_data_i[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // length in use: zero reads as one, long values saturate
  always_comb begin
    if (len_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (len_q > LEN_W'(LenCap)) begin
      eff_len = LEN_W'(LenCap);
    end else begin
      eff_len = len_q;
    end
  end

  assign cmp.pat  = pat_q;
  assign cmp.care = care_q;
  assign cmp.len  = eff_len;

  assign s_axis_tready = !buf_st.skid_vld;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign shift         = accept && !matched_q;

  // window cell row, newest byte in cell 0
  generate
    for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
      if (i == 0) begin : g_head
        assign win_in[i] = s_axis_tdata;
      end else begin : g_link
        assign win_in[i] = win_out[i-1];
      end
      mbps_cell #(.IDX(i)) u_cell (
        .clk_i      (clk_i),
        .shift_en_i (shift),
        .byte_i     (win_in[i]),
        .cmp_i      (cmp),
        .byte_o     (win_out[i]),
        .hit_o      (hits[i])
      );
    end
  endgenerate

  // count, match decision and start address
  assign seen_new = (seen_q == '1) ? seen_q : seen_q + SEEN_W'(1);
  assign match    = (seen_new >= SEEN_W'(eff_len)) && (&hits);
  assign diff     = seen_new - SEEN_W'(eff_len);
  assign addr     = base_q + (ADDR_W'(diff) & OffMask);

  assign res_push      = shift && (match || s_axis_tlast);
  assign res_new.found = match;
  assign res_new.addr  = match ? addr : '0;

  always_comb begin
    seen_d    = seen_q;
    matched_d = matched_q;
    if (accept && s_axis_tlast) begin
      seen_d    = '0;
      matched_d = 1'b0;
    end else if (shift) begin
      seen_d    = seen_new;
      matched_d = match;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q    <= '0;
      matched_q <= 1'b0;
    end else begin
      seen_q    <= seen_d;
      matched_q <= matched_d;
    end
  end

  // result buffer
  mbps_obuf u_obuf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (res_push),
    .res_i    (res_new),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .res_o    (res_out),
    .status_o (buf_st)
  );

  assign m_axis_tdata = res_out.addr;
  assign m_axis_tuser = res_out.found;

  // checks
  a_skid_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    buf_st.skid_vld |-> buf_st.head_vld)
    else $error("skid entry held with empty head");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    matched_q |-> !res_push)
    else $error("second result in one region");

  a_miss_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && !res_new.found) |-> s_axis_tlast)
    else $error("not-found beat before end of region");

  a_miss_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("not-found beat with non-zero address");

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench: masked byte pattern scanner
// Streams byte regions into the scanner and predicts each found / not-found
// result beat in step with the accepted bytes; the result stream is checked
// beat by beat. A few directed cases come first, then random regions with
// planted, broken and absent patterns under several idling profiles.
// ---------------------------------------------------------------------------
module testbench;
  import mbps_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;  // not a register
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [PAT_BYTES*8-1:0] pat;
    logic [PAT_BYTES-1:0]   care;
    logic [LEN_W-1:0]       len;
    logic [ADDR_W-1:0]      base;
  } scan_cfg_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata = '0;
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [ADDR_W-1:0]    m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;

  // predictor copy of the configuration (reset values)
  logic [PAT_BYTES*8-1:0] pred_pat = '0;
  logic [PAT_BYTES-1:0]   pred_care = '1;
  logic [LEN_W-1:0]       pred_len = 6'd1;
  logic [ADDR_W-1:0]      pred_base = '0;

  // predictor copy of the scan state
  logic [7:0]  window [PAT_BYTES];
  logic [31:0] bytes_seen = '0;
  bit          scan_matched = 1'b0;

  res_t        expected_results [$];
  res_t        want;
  int unsigned failures = 0;
  int unsigned live_bytes = 0;     // byte beats sent so far
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles = 0;

  masked_byte_pattern_scanner DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // pattern length in use: zero counts as one, above 32 saturates
  function automatic int unsigned eff_len(input logic [LEN_W-1:0] l);
    if (l == 0) return 1;
    if (l > PAT_BYTES) return PAT_BYTES;
    return 32'(l);
  endfunction

  // advance the scan by one byte; returns 1 when a result beat is due
  function automatic bit scan_byte(input logic [7:0] b, input logic lst, output res_t r);
    int unsigned n;
    logic [31:0] off;
    bit hit;
    bit produced;
    produced = 1'b0;
    r = '0;
    if (!scan_matched) begin
      n = eff_len(pred_len);
      for (int k = PAT_BYTES - 1; k > 0; k--) window[k] = window[k-1];
      window[0] = b;
      if (bytes_seen != '1) bytes_seen++;
      hit = (bytes_seen >= n);
      for (int j = 0; j < n; j++)
        if (pred_care[j] && pred_pat[j*8 +: 8] != window[n-1-j]) hit = 1'b0;
      if (hit) begin
        off = bytes_seen - n;
        scan_matched = 1'b1;
        r.found = 1'b1;
        r.addr = pred_base + 48'(off);
        produced = 1'b1;
      end else if (lst) begin
        produced = 1'b1;
      end
    end
    // region end clears the scan state
    if (lst) begin
      foreach (window[k]) window[k] = '0;
      bytes_seen = '0;
      scan_matched = 1'b0;
    end
    return produced;
  endfunction

  // one byte beat on the input stream, with random idling before it
  task automatic send_byte(input logic [7:0] b, input logic lst);
    res_t r;
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    live_bytes++;
    if (scan_byte(b, lst, r)) expected_results.push_back(r);
  endtask

  // stop the stream and let every expected beat come out
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // write every register, plus the spare index which must be ignored
  task automatic configure(input scan_cfg_t c);
    logic [CFG_IDX_W-1:0] idx [8];
    logic [CFG_DAT_W-1:0] val [8];
    idx = '{REG_PAT_LOW, REG_PAT_SECOND, REG_PAT_THIRD, REG_PAT_HIGH,
            REG_CARE, REG_LEN, REG_BASE, CFG_IDX_SPARE};
    val = '{c.pat[63:0], c.pat[127:64], c.pat[191:128], c.pat[255:192],
            64'(c.care), 64'(c.len), 64'(c.base), {$urandom, $urandom}};
    for (int k = 0; k < 8; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_data_i  <= val[k];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (idx[k])
        REG_PAT_LOW, REG_PAT_SECOND, REG_PAT_THIRD, REG_PAT_HIGH: begin
          pred_pat[idx[k]*64 +: 64] = val[k];
        end
        REG_CARE: begin
          pred_care = val[k][PAT_BYTES-1:0];
        end
        REG_LEN: begin
          pred_len = val[k][LEN_W-1:0];
        end
        REG_BASE: begin
          pred_base = val[k][ADDR_W-1:0];
        end
        default: begin
        end
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  // one random region: pattern planted whole, planted broken, or absent
  task automatic scan_region(input scan_cfg_t c);
    logic [7:0] region [$];
    int unsigned n;
    int unsigned len;
    int unsigned mode;
    int unsigned start;
    int unsigned j;
    n = eff_len(c.len);
    if ($urandom_range(9) == 0) len = $urandom_range(1, n);
    else len = n + $urandom_range(0, 24);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(1)) region.push_back(c.pat[$urandom_range(n - 1)*8 +: 8]);
      else region.push_back(8'($urandom_range(255)));
    end
    mode = $urandom_range(9);
    if (len >= n && mode < 8) begin
      start = $urandom_range(0, len - n);
      for (int p = 0; p < n; p++)
        if (c.care[p] || $urandom_range(1)) region[start+p] = c.pat[p*8 +: 8];
      // broken copy: spoil one byte that must match
      if (mode >= 6) begin
        j = $urandom_range(n - 1);
        if (c.care[j]) region[start+j] ^= 8'($urandom_range(1, 255));
      end
    end
    for (int i = 0; i < len; i++) send_byte(region[i], i == len - 1);
  endtask

  // result check against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result beat: found %0d, match_address %h",
               m_axis_tuser, m_axis_tdata);
        failures++;
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tuser !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, m_axis_tuser);
          failures++;
        end
        if (m_axis_tdata !== want.addr) begin
          $error("match_address: expected %h, actual %h", want.addr, m_axis_tdata);
          failures++;
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // reset configuration: pattern zero, length one, every byte cared
  task automatic test_reset_defaults();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
  endtask

  // wildcard in the middle, match on the final byte, address wrap
  task automatic test_wildcard_last_byte();
    scan_cfg_t c;
    wait_idle();
    c = '0;
    c.pat[23:0] = 24'hCD_5A_AB;
    c.care = 32'h5;
    c.len = 6'd3;
    c.base = '1;
    configure(c);
    send_byte(8'h11, 1'b0);
    send_byte(8'hAB, 1'b0);
    send_byte(8'h77, 1'b0);
    send_byte(8'hCD, 1'b1);
  endtask

  // bytes after a match are ignored; the next region starts clean
  task automatic test_after_match();
    scan_cfg_t c;
    wait_idle();
    c = '0;
    c.pat[23:0] = 24'hCD_00_AB;
    c.care = 32'h5;
    c.len = 6'd3;
    c.base = 48'h1000;
    configure(c);
    send_byte(8'hAB, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hCD, 1'b0);
    send_byte(8'hAB, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hAB, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hCD, 1'b1);
  endtask

  // region shorter than the pattern never matches
  task automatic test_short_region();
    send_byte(8'hAB, 1'b0);
    send_byte(8'hCD, 1'b1);
  endtask

  // length zero behaves as one; lengths above 32 saturate
  task automatic test_length_limits();
    scan_cfg_t c;
    wait_idle();
    c = '0;
    c.pat[7:0] = 8'h5A;
    c.care = '1;
    c.len = 6'd0;
    c.base = 48'h8000_0000_0000;
    configure(c);
    send_byte(8'h5A, 1'b1);
    wait_idle();
    c.care = '0;
    c.len = 6'd63;
    configure(c);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h3C, 1'b1);
  endtask

  // configuration changed while a region is open
  task automatic test_mid_region_config();
    scan_cfg_t c;
    wait_idle();
    c = '0;
    c.pat[7:0] = 8'h42;
    c.care = '1;
    c.len = 6'd1;
    c.base = 48'h0000_1234_5678;
    configure(c);
    send_byte(8'h10, 1'b0);
    send_byte(8'h30, 1'b0);
    wait_idle();
    c.pat[7:0] = 8'h30;
    configure(c);
    send_byte(8'h30, 1'b1);
  endtask

  // random configurations and regions under one idling profile
  task automatic test_random_regions(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input int unsigned quota);
    scan_cfg_t c;
    int unsigned stop_at;
    int unsigned group_end;
    int unsigned pick;
    sender_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at = live_bytes + quota;
    while (live_bytes < stop_at) begin
      for (int w = 0; w < 8; w++) c.pat[w*32 +: 32] = $urandom;
      case ($urandom_range(3))
        0: c.care = '1;
        1: c.care = $urandom;
        2: c.care = ~(32'h1 << $urandom_range(31));
        default: c.care = $urandom & $urandom;
      endcase
      pick = $urandom_range(19);
      if (pick == 0) c.len = 6'd0;
      else if (pick <= 2) c.len = 6'd32;
      else if (pick == 3) c.len = 6'($urandom_range(33, 63));
      else if (pick <= 6) c.len = 6'($urandom_range(9, 31));
      else c.len = 6'($urandom_range(1, 8));
      case ($urandom_range(5))
        0: c.base = '0;
        1: c.base = '1;
        2: c.base = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(64));
        default: c.base = {16'($urandom), 32'($urandom)};
      endcase
      wait_idle();
      configure(c);
      group_end = live_bytes + $urandom_range(40, 100);
      while (live_bytes < group_end) scan_region(c);
    end
  endtask

  initial begin
    foreach (window[k]) window[k] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_wildcard_last_byte();
    test_after_match();
    test_short_region();
    test_length_limits();
    test_mid_region_config();
    test_random_regions(0, 0, 340);
    test_random_regions(81, 0, 330);
    test_random_regions(0, 81, 330);
    test_random_regions(17, 17, 330);
    wait_idle();
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
